// ----- design/atanrr_pkg.sv -----
// ----------------------------------------------------------------------------
// atanrr_pkg
// Shared constants of the range-reduced arctangent block: fixed-point
// formats, Q30 coefficients and the per-step angle offsets.
// ----------------------------------------------------------------------------
package atanrr_pkg;

  // default argument format Q(31-F).F
  localparam int DEF_FRAC_BITS = 16;

  // divider geometry: dividend/remainder width and quotient bits
  localparam int DW = 62;
  localparam int QW = 31;

  // Q30 coefficients, rounded to nearest
  localparam logic [31:0] K_SQRT3   = 32'd1859775393;
  localparam logic [31:0] K_DEN_ADD = 32'd1512667295;
  localparam logic [31:0] K_NUM     = 32'd600368879;
  localparam logic [31:0] K_LIN     = 32'd647579911;
  localparam logic [31:0] K_SQ      = 32'd55409953;

  // Q30 angles
  localparam logic signed [31:0] K_PI12 = 32'sd281104952;
  localparam logic signed [35:0] K_PI6  = 36'sd562209904;
  localparam logic signed [35:0] K_PI2  = 36'sd1686629713;

  // reduction step cap
  localparam logic [1:0] MAX_STEPS = 2'd3;

  // angle added back for a number of reduction steps
  function automatic logic signed [35:0] steps_angle(input logic [1:0] steps);
    logic signed [35:0] res;
    case (steps)
      2'd0:    res = 36'sd0;
      2'd1:    res = K_PI6;
      2'd2:    res = K_PI6 + K_PI6;
      default: res = K_PI6 + K_PI6 + K_PI6;
    endcase
    return res;
  endfunction

endpackage

// ----- design/arctan_range_reduced.sv -----
// ----------------------------------------------------------------------------
// arctan_range_reduced
// Arctangent of a signed fixed-point argument with sign folding, reciprocal
// and pi/6 range reduction, then a rational core. One shared 32x32
// multiplier and one shared radix-2 divider run under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  ports                    width  notes
//  -------  -----------------------  -----  -------------------------------
//  input    start, busy, in_x_value  32     signed Q(31-F).F, taken on
//                                           start & !busy
//  result   out_valid, out_angle     32     signed Q2.29, one-cycle strobe
//
// A word takes longer from accept to strobe when |x| > 1 and for each pi/6
// reduction step (at most two for real inputs).
// The divider retires one quotient bit a cycle over 31 bits and serves the
// reciprocal, each reduction step and the core.
// busy is high from the accept until the strobe cycle, when it drops.
// Reset (rst_n low, synchronous) returns the sequencer and divider to idle.
// The receiver cannot stall: a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module arctan_range_reduced #(
  parameter int INPUT_FRACTION_BITS = atanrr_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_x_value,
  output logic               out_valid,
  output logic signed [31:0] out_angle
);

  localparam int DW = atanrr_pkg::DW;
  localparam int QW = atanrr_pkg::QW;
  localparam int UP_SHIFT = 30 - INPUT_FRACTION_BITS;
  localparam logic [DW-1:0] RECIP_NUM = DW'(1) << (30 + INPUT_FRACTION_BITS);
  localparam logic [32:0] ONE_IN = 33'd1 << INPUT_FRACTION_BITS;
  localparam logic signed [63:0] Q60_ONE = 64'sd1 <<< 60;
  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RECIP = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_RMUL  = 4'd3;
  localparam logic [3:0] S_RLOAD = 4'd4;
  localparam logic [3:0] S_RDIV  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_SQR   = 4'd7;
  localparam logic [3:0] S_KSQ   = 4'd8;
  localparam logic [3:0] S_KSQR  = 4'd9;
  localparam logic [3:0] S_CDIV  = 4'd10;
  localparam logic [3:0] S_AMUL  = 4'd11;
  localparam logic [3:0] S_FIN1  = 4'd12;
  localparam logic [3:0] S_FIN2  = 4'd13;

  logic [3:0]         state_r, state_nxt;
  logic               neg_r, inv_r, qneg_r, mneg_r;
  logic signed [31:0] x_r;
  logic [1:0]         steps_r;
  logic [30:0]        m_r, x2_r, sq_r;
  logic [31:0]        a_r;
  logic signed [35:0] ang_r;
  logic [63:0]        prod_r;
  logic               out_valid_r;
  logic signed [31:0] out_angle_r;

  // divider registers
  logic [DW-1:0]      div_rem_r, div_dsr_r;
  logic [QW-1:0]      div_q_r;
  logic [4:0]         div_cnt_r;
  logic               div_busy_r;

  logic               accept;
  logic [31:0]        in_mag;
  logic               in_inv;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod_rnd;
  logic signed [63:0] num_s, num_abs;
  logic [31:0]        rden, cden;
  logic [30:0]        x2_new;
  logic               div_ld;
  logic [DW-1:0]      div_ld_num;
  logic [31:0]        div_ld_den;
  logic               div_ge;
  logic signed [31:0] q_s;
  logic signed [35:0] r_s, ang_adj, ang_rnd;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

  // magnitude of the argument, the most negative code maps to 2^31 exactly
  assign in_mag = in_x_value[31] ? (32'd0 - 32'(in_x_value)) : 32'(in_x_value);
  assign in_inv = {1'b0, in_mag} > ONE_IN;

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_RMUL: begin
        mul_a = 32'(x_r);
        mul_b = atanrr_pkg::K_SQRT3;
      end
      S_SQ: begin
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, m_r};
      end
      S_KSQ: begin
        mul_a = atanrr_pkg::K_SQ;
        mul_b = {1'b0, x2_r};
      end
      S_AMUL: begin
        mul_a = {1'b0, m_r};
        mul_b = a_r;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // registered product and its Q30 rounding
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  assign prod_rnd = prod_r + HALF_Q30;
  assign x2_new   = prod_rnd[60:30];

  // reduction step numerator x*sqrt3 - 1 and denominator x + sqrt3
  assign num_s   = $signed(prod_r) - Q60_ONE;
  assign num_abs = num_s[63] ? -num_s : num_s;
  assign rden    = 32'(x_r) + atanrr_pkg::K_SQRT3;

  // core denominator x^2 + 1.4087812
  assign cden = {1'b0, x2_new} + atanrr_pkg::K_DEN_ADD;

  // divider load select
  always_comb begin
    div_ld     = 1'b0;
    div_ld_num = '0;
    div_ld_den = 32'd0;
    unique case (state_r)
      S_IDLE: begin
        div_ld     = accept && in_inv;
        div_ld_num = RECIP_NUM + DW'(in_mag[31:1]);
        div_ld_den = in_mag;
      end
      S_RLOAD: begin
        div_ld     = 1'b1;
        div_ld_num = num_abs[DW-1:0];
        div_ld_den = rden;
      end
      S_SQR: begin
        div_ld     = 1'b1;
        div_ld_num = DW'({atanrr_pkg::K_NUM, 30'd0}) + DW'(cden[31:1]);
        div_ld_den = cden;
      end
      default: begin
        div_ld = 1'b0;
      end
    endcase
  end

  // restoring divider, one quotient bit a cycle
  assign div_ge = (div_rem_r >= div_dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= 5'd0;
    end else if (div_ld) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= 5'(QW - 1);
      div_rem_r  <= div_ld_num;
      div_dsr_r  <= DW'(div_ld_den) << (QW - 1);
      div_q_r    <= '0;
    end else if (div_busy_r) begin
      if (div_ge) begin
        div_rem_r <= div_rem_r - div_dsr_r;
      end
      div_q_r   <= {div_q_r[QW-2:0], div_ge};
      div_dsr_r <= div_dsr_r >> 1;
      div_cnt_r <= div_cnt_r - 5'd1;
      if (div_cnt_r == 5'd0) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  assign q_s = {1'b0, div_q_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = in_inv ? S_RECIP : S_CHECK;
      end
      S_RECIP: begin
        if (!div_busy_r) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if ((x_r > atanrr_pkg::K_PI12) && (steps_r != atanrr_pkg::MAX_STEPS)) begin
          state_nxt = S_RMUL;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_RMUL:  state_nxt = S_RLOAD;
      S_RLOAD: state_nxt = S_RDIV;
      S_RDIV: begin
        if (!div_busy_r) state_nxt = S_CHECK;
      end
      S_SQ:   state_nxt = S_SQR;
      S_SQR:  state_nxt = S_KSQ;
      S_KSQ:  state_nxt = S_KSQR;
      S_KSQR: state_nxt = S_CDIV;
      S_CDIV: begin
        if (!div_busy_r) state_nxt = S_AMUL;
      end
      S_AMUL: state_nxt = S_FIN1;
      S_FIN1: state_nxt = S_FIN2;
      S_FIN2: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_FIN2);
    end
  end

  // core product back to signed and the pi/6 steps added
  assign r_s = {2'b00, prod_rnd[63:30]};

  // quadrant fix for inversion and sign, then Q30 to Q29 rounding
  always_comb begin
    case ({inv_r, neg_r})
      2'b11:   ang_adj = ang_r - atanrr_pkg::K_PI2;
      2'b10:   ang_adj = atanrr_pkg::K_PI2 - ang_r;
      2'b01:   ang_adj = -ang_r;
      default: ang_adj = ang_r;
    endcase
  end

  assign ang_rnd = ang_adj + 36'sd1;

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_r   <= in_x_value[31];
          inv_r   <= in_inv;
          steps_r <= 2'd0;
          x_r     <= $signed(in_mag << UP_SHIFT);
        end
      end
      S_RECIP: begin
        if (!div_busy_r) x_r <= q_s;
      end
      S_CHECK: begin
        mneg_r <= x_r[31];
        m_r    <= x_r[31] ? 31'(-x_r) : x_r[30:0];
      end
      S_RLOAD: begin
        qneg_r <= num_s[63];
      end
      S_RDIV: begin
        if (!div_busy_r) begin
          x_r     <= qneg_r ? -q_s : q_s;
          steps_r <= steps_r + 2'd1;
        end
      end
      S_SQR: begin
        x2_r <= x2_new;
      end
      S_KSQR: begin
        sq_r <= x2_new;
      end
      S_CDIV: begin
        if (!div_busy_r) begin
          a_r <= 32'(q_s) + atanrr_pkg::K_LIN - {1'b0, sq_r};
        end
      end
      S_FIN1: begin
        ang_r <= mneg_r ? (atanrr_pkg::steps_angle(steps_r) - r_s)
                        : (atanrr_pkg::steps_angle(steps_r) + r_s);
      end
      S_FIN2: begin
        out_angle_r <= ang_rnd[32:1];
      end
      default: begin
      end
    endcase
  end

  // checks on the sequencer and shared divider
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while sequencer still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_busy_r)
    else $error("divider running while sequencer idle");

endmodule

// ----- verif/arctan_range_reduced_tb.sv -----
// ----------------------------------------------------------------------------
// arctan_range_reduced_tb
// Self-checking bench for the range-reduced arctangent block. Arguments go in
// through the start/busy command port. A bit-exact fixed-point predictor
// computes each angle when its word is taken. The one-cycle result strobes
// are checked in order against those angles.
// ----------------------------------------------------------------------------
module arctan_range_reduced_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = atanrr_pkg::DEF_FRAC_BITS;
  localparam int ONE_ARG     = 1 << FRAC;
  localparam int DRAIN_HOLD  = 150;

  // q30 constants of the approximation
  localparam longint Q30_PI12    = 64'sd281104952;
  localparam longint Q30_PI6     = 64'sd562209904;
  localparam longint Q30_PI2     = 64'sd1686629713;
  localparam longint Q30_SQRT3   = 64'sd1859775393;
  localparam longint Q30_DEN_ADD = 64'sd1512667295;
  localparam longint Q30_NUM     = 64'sd600368879;
  localparam longint Q30_LIN     = 64'sd647579911;
  localparam longint Q30_SQ      = 64'sd55409953;
  localparam int     STEP_CAP    = 3;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] angle;
  } angle_exp_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_x_value;
  logic               out_valid;
  logic signed [31:0] out_angle;

  angle_exp_t pending_angles[$];
  int         errors   = 0;
  int         idle_max = 18;

  arctan_range_reduced #(
    .INPUT_FRACTION_BITS(FRAC)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_x_value(in_x_value),
    .out_valid (out_valid),
    .out_angle (out_angle)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // q30 product, rounded half toward plus infinity
  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // rational core on a q30 argument, sign restored after the magnitude path
  function automatic longint rational_core(input longint x);
    longint m, x2, den, t, a, r;
    m   = (x < 0) ? -x : x;
    x2  = q30_mul(m, m);
    den = x2 + Q30_DEN_ADD;
    t   = ((Q30_NUM <<< 30) + den / 2) / den;
    a   = t + Q30_LIN - q30_mul(Q30_SQ, x2);
    r   = q30_mul(m, a);
    return (x < 0) ? -r : r;
  endfunction

  // expected q2.29 angle for one argument
  function automatic logic signed [31:0] predict_angle(input logic signed [31:0] arg);
    logic [31:0] raw;
    logic        neg, inv;
    longint      mag, x, num, den, ang;
    int          steps;
    raw   = arg;
    neg   = raw[31];
    mag   = neg ? ((64'sd1 <<< 32) - longint'(raw)) : longint'(raw);
    inv   = mag > ONE_ARG;
    steps = 0;
    // fold into [0, 1]
    if (inv)
      x = ((64'sd1 <<< (30 + FRAC)) + mag / 2) / mag;
    else
      x = mag <<< (30 - FRAC);
    // pi/6 reduction steps
    while (x > Q30_PI12 && steps < STEP_CAP) begin
      num = x * Q30_SQRT3 - (64'sd1 <<< 60);
      den = x + Q30_SQRT3;
      x   = num / den;
      steps++;
    end
    ang = rational_core(x) + steps * Q30_PI6;
    if (inv)
      ang = Q30_PI2 - ang;
    if (neg)
      ang = -ang;
    // q30 to q29, half toward plus infinity
    ang = (((ang + (64'sd1 <<< 40)) + 1) >>> 1) - (64'sd1 <<< 39);
    return ang[31:0];
  endfunction

  // random argument drawn over several magnitude classes
  function automatic logic signed [31:0] rand_arg();
    logic [31:0] v;
    int          kind;
    kind = $urandom_range(0, 3);
    case (kind)
      0:       v = $urandom;
      1:       v = $urandom >> $urandom_range(0, 31);
      2:       v = ONE_ARG + $urandom_range(0, 512) - 256;
      default: v = $urandom_range(0, 3 * ONE_ARG);
    endcase
    if (kind != 0 && $urandom_range(0, 1) == 1)
      v = -v;
    return v;
  endfunction

  // send one word, record its angle when it is taken
  task automatic send_word(input logic signed [31:0] x);
    int gap;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_x_value <= x;
    do @(posedge clk); while (busy);
    pending_angles.push_back('{x: x, angle: predict_angle(x)});
  endtask

  // stop sending and wait for every outstanding angle
  task automatic wait_all_angles();
    start <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  // check each strobed angle against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected angle word: expected none, got %h", $time, out_angle);
        errors++;
      end else begin
        angle_exp_t e;
        e = pending_angles.pop_front();
        if (out_angle !== e.angle) begin
          $display("%0t: angle mismatch for x=%h: expected %h, got %h",
                   $time, e.x, e.angle, out_angle);
          errors++;
        end
      end
    end
  end

  // extremes, sign and inversion edges, reduction thresholds
  task automatic test_directed();
    logic signed [31:0] args[] = '{
      32'sd0, 32'sd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
      ONE_ARG, -ONE_ARG, ONE_ARG + 1, ONE_ARG - 1, -(ONE_ARG + 1),
      ONE_ARG / 2, 2 * ONE_ARG, -(2 * ONE_ARG),
      17157, 17158, 17561, -17561, 37837, 113512,
      32'h0100_0000, 32'h00FF_FFFF, -32'sd2, 32'h4000_0000
    };
    idle_max = 18;
    foreach (args[i])
      send_word(args[i]);
  endtask

  // broad random arguments with idle and back-to-back stretches
  task automatic test_random_spread();
    for (int i = 0; i < 700; i++) begin
      if (i % 64 == 0)
        idle_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
      send_word(rand_arg());
    end
  endtask

  // arguments around the unit range where reduction steps happen
  task automatic test_unit_range();
    logic signed [31:0] v;
    idle_max = 18;
    for (int i = 0; i < 600; i++) begin
      if (i % 50 == 0)
        idle_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
      v = $urandom_range(0, ONE_ARG + ONE_ARG / 2);
      send_word(($urandom_range(0, 1) == 1) ? -v : v);
    end
  endtask

  // words offered with no gap at all
  task automatic test_back_to_back();
    idle_max = 0;
    for (int i = 0; i < 300; i++)
      send_word(rand_arg());
  endtask

  // bursts separated by full drains
  task automatic test_drain_pauses();
    idle_max = 18;
    for (int b = 0; b < 8; b++) begin
      repeat ($urandom_range(5, 30))
        send_word(rand_arg());
      wait_all_angles();
    end
  endtask

  // sequence of tests
  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_x_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_spread();
    test_unit_range();
    test_back_to_back();
    test_drain_pauses();

    wait_all_angles();
    repeat (DRAIN_HOLD) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
design/atanrr_pkg.sv
design/arctan_range_reduced.sv
verif/arctan_range_reduced_tb.sv
